/* sv/slab_object_allocator_core_macros.svh */
// Assertion macros for the slab object allocator core.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef SLAB_OBJECT_ALLOCATOR_CORE_MACROS_SVH
`define SLAB_OBJECT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define SOA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define SOA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/soa_pkg.sv */
// Shared types and constants of the slab object allocator core.
// Depends on nothing.
package soa_pkg;

  localparam int CMD_W  = 2;
  localparam int SLAB_W = 4;
  localparam int OBJ_W  = 7;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 8;
  localparam int DATA_W = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_DESTROY = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SLAB    = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_DESTROYED  = 2'd3
  } status_t;

  // Slab class of a claimed slab; slabs not yet claimed are tracked by a counter.
  typedef enum logic [1:0] {
    CLS_PARTIAL = 2'd1,
    CLS_FULL    = 2'd2,
    CLS_EMPTY   = 2'd3
  } cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_STK,
    S_NBRD,
    S_NBWR,
    S_DONE
  } fsm_t;

endpackage

/* sv/slab_object_allocator_core.sv */
// Slab object allocator core: slab records and free stacks in two RAMs.
// Depends on soa_pkg and slab_object_allocator_core_macros.svh.
//
// Channel  Dir  Payload
// cfg      in   cfg_data: objects_per_slab
// in       in   in_tuser: command; in_tdata: slab_index, object_index
// out      out  out_tuser: status; out_tdata: granted_slab, granted_object
//
// One beat is taken at a time. Destroy and unknown commands go straight to the
// final state; allocate and free pass through evaluation, then a stack read
// when the popped object comes from the stack RAM, then a read and a rewrite of
// each neighbor record of the partial list that changes (at most two).
// Reset clears the slab counter and list head, not the RAMs; no clearing pass runs.
// A result waiting on out_tready holds the core in its final state.
`include "slab_object_allocator_core_macros.svh"

module slab_object_allocator_core #(
  parameter int MAX_SLABS   = 16,
  parameter int MAX_OBJECTS = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [soa_pkg::CFG_W-1:0]   cfg_data,   // objects_per_slab
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [soa_pkg::DATA_W-1:0]  in_tdata,   // slab_index[3:0], object_index[10:4]
  input  logic [soa_pkg::CMD_W-1:0]   in_tuser,   // command[1:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [soa_pkg::DATA_W-1:0]  out_tdata,  // granted_slab[3:0], granted_object[10:4]
  output logic [soa_pkg::STAT_W-1:0]  out_tuser   // status[1:0]
);
  import soa_pkg::*;

  localparam int SW    = $clog2(MAX_SLABS);
  localparam int PW    = $clog2(MAX_SLABS + 1);
  localparam int CW    = $clog2(MAX_OBJECTS + 1);
  localparam int OW    = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int DEPTH = MAX_SLABS * MAX_OBJECTS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [PW-1:0] NONE = PW'(MAX_SLABS);

  // One slab record; low is the lowest stack slot written since the claim.
  typedef struct packed {
    cls_t          cls;
    logic [CW-1:0] cnt;
    logic [CW-1:0] tot;
    logic [CW-1:0] low;
    logic [PW-1:0] nxt;
    logic [PW-1:0] prv;
  } rec_t;

  // Pending update of one link field in a neighbor record.
  typedef struct packed {
    logic [PW-1:0] addr;
    logic          set_next;
    logic [PW-1:0] val;
  } nbop_t;

  fsm_t               state_r, state_nxt;
  logic [CFG_W-1:0]   cfg_r;
  logic [PW-1:0]      unused_r, unused_nxt;
  logic [PW-1:0]      head_r, head_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic               bad_r, bad_nxt;
  logic [SW-1:0]      s_r, s_nxt;
  logic [OBJ_W-1:0]   oi_r, oi_nxt;
  nbop_t              nb_r [2];
  nbop_t              nb_nxt [2];
  logic [1:0]         nbv_r, nbv_nxt;
  status_t            res_st_r, res_st_nxt;
  logic [SW-1:0]      res_gs_r, res_gs_nxt;
  logic [OW-1:0]      res_go_r, res_go_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_st_r;
  logic [SLAB_W-1:0]  out_gs_r;
  logic [OBJ_W-1:0]   out_go_r;

  rec_t               rec_mem [MAX_SLABS];
  rec_t               rec_q, rec_wdata;
  logic               rec_we;
  logic [SW-1:0]      rec_waddr, rec_raddr;
  logic [OW-1:0]      stk_mem [DEPTH];
  logic [OW-1:0]      stk_q, stk_wdata;
  logic               stk_we;
  logic [AW-1:0]      stk_waddr, stk_raddr;

  logic               in_acc, out_free, nb_sel, eval_stk;
  logic [SLAB_W-1:0]  in_slab;
  logic [OBJ_W-1:0]   in_obj;
  logic [CW-1:0]      tot_new, pos, cnt_upd;
  nbop_t              nb_cur;
  rec_t               nb_rec;

  assign in_slab   = in_tdata[SLAB_W-1:0];
  assign in_obj    = in_tdata[SLAB_W+OBJ_W-1:SLAB_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign nb_sel    = !nbv_r[0];
  assign nb_cur    = nb_r[nb_sel];

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = DATA_W'({out_go_r, out_gs_r});

  // Object count latched into a new slab, clamped to the pool geometry.
  always_comb begin
    if (cfg_r == '0) begin
      tot_new = CW'(1);
    end else if (32'(cfg_r) > MAX_OBJECTS) begin
      tot_new = CW'(MAX_OBJECTS);
    end else begin
      tot_new = CW'(cfg_r);
    end
  end

  // Record RAM: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_q <= rec_mem[rec_raddr];
  end

  // Free stack RAM: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk_mem[stk_raddr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == CMD_ALLOC || in_tuser == CMD_FREE) begin
            state_nxt = S_EVAL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_EVAL: begin
        if (eval_stk) begin
          state_nxt = S_STK;
        end else if (nbv_nxt != '0) begin
          state_nxt = S_NBRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_STK:  state_nxt = (nbv_r != '0) ? S_NBRD : S_DONE;
      S_NBRD: state_nxt = S_NBWR;
      S_NBWR: state_nxt = (nbv_nxt != '0) ? S_NBRD : S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, RAM strobes and result values.
  always_comb begin
    unused_nxt    = unused_r;
    head_nxt      = head_r;
    cmd_nxt       = cmd_r;
    bad_nxt       = bad_r;
    s_nxt         = s_r;
    oi_nxt        = oi_r;
    nb_nxt        = nb_r;
    nbv_nxt       = nbv_r;
    res_st_nxt    = res_st_r;
    res_gs_nxt    = res_gs_r;
    res_go_nxt    = res_go_r;
    out_valid_nxt = out_valid_r;
    eval_stk      = 1'b0;
    rec_we        = 1'b0;
    rec_waddr     = s_r;
    rec_wdata     = rec_q;
    rec_raddr     = s_r;
    stk_we        = 1'b0;
    stk_wdata     = OW'(oi_r);
    pos           = rec_q.tot - rec_q.cnt - CW'(1);
    cnt_upd       = rec_q.cnt;
    nb_rec        = rec_q;
    stk_waddr     = AW'(s_r) * AW'(MAX_OBJECTS) + AW'(rec_q.tot - rec_q.cnt);
    stk_raddr     = AW'(s_r) * AW'(MAX_OBJECTS) + AW'(pos);

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // Take a beat and pick the slab whose record is read.
      S_IDLE: begin
        if (head_r != NONE) begin
          rec_raddr = SW'(head_r);
        end else begin
          rec_raddr = SW'(unused_r);
        end
        if (in_tuser != CMD_ALLOC) begin
          rec_raddr = SW'(in_slab);
        end
        if (in_acc) begin
          cmd_nxt    = cmd_t'(in_tuser);
          s_nxt      = rec_raddr;
          oi_nxt     = in_obj;
          bad_nxt    = !(32'(in_slab) < 32'(unused_r));
          nbv_nxt    = '0;
          res_gs_nxt = '0;
          res_go_nxt = '0;
          res_st_nxt = ST_BAD_HANDLE;
          if (in_tuser == CMD_DESTROY) begin
            unused_nxt = '0;
            head_nxt   = NONE;
            res_st_nxt = ST_DESTROYED;
          end
        end
      end

      // Record data is here: decide and, unless the command fails, write the slab's record back.
      S_EVAL: begin
        if (cmd_r == CMD_ALLOC) begin
          if (head_r == NONE) begin
            if (unused_r == NONE) begin
              res_st_nxt = ST_NO_SLAB;
            end else begin
              // Claim the next unused slab and pop its top object at once.
              rec_we        = 1'b1;
              rec_wdata.cls = (tot_new == CW'(1)) ? CLS_FULL : CLS_PARTIAL;
              rec_wdata.cnt = CW'(1);
              rec_wdata.tot = tot_new;
              rec_wdata.low = tot_new;
              rec_wdata.nxt = NONE;
              rec_wdata.prv = NONE;
              head_nxt      = (tot_new == CW'(1)) ? NONE : PW'(s_r);
              unused_nxt    = unused_r + PW'(1);
              res_st_nxt    = ST_OK;
              res_gs_nxt    = s_r;
              res_go_nxt    = OW'(tot_new - CW'(1));
            end
          end else begin
            // Pop from the head slab; slots below low still hold their index.
            cnt_upd       = rec_q.cnt + CW'(1);
            rec_we        = 1'b1;
            rec_wdata.cnt = cnt_upd;
            res_st_nxt    = ST_OK;
            res_gs_nxt    = s_r;
            res_go_nxt    = OW'(pos);
            eval_stk      = (pos >= rec_q.low);
            if (cnt_upd >= rec_q.tot) begin
              rec_wdata.cls = CLS_FULL;
              head_nxt      = rec_q.nxt;
              if (rec_q.nxt != NONE) begin
                nb_nxt[0] = '{addr: rec_q.nxt, set_next: 1'b0, val: NONE};
                nbv_nxt[0] = 1'b1;
              end
            end
          end
        end else if (!bad_r && rec_q.cls != CLS_EMPTY &&
                     32'(oi_r) < 32'(rec_q.tot)) begin
          // Push the freed object and fix the list membership.
          stk_we        = 1'b1;
          cnt_upd       = rec_q.cnt - CW'(1);
          rec_we        = 1'b1;
          rec_wdata.cnt = cnt_upd;
          if ((rec_q.tot - rec_q.cnt) < rec_q.low) begin
            rec_wdata.low = rec_q.tot - rec_q.cnt;
          end
          res_st_nxt = ST_OK;
          if (cnt_upd == '0) begin
            rec_wdata.cls = CLS_EMPTY;
            if (rec_q.cls == CLS_PARTIAL) begin
              if (rec_q.prv != NONE) begin
                nb_nxt[0] = '{addr: rec_q.prv, set_next: 1'b1, val: rec_q.nxt};
                nbv_nxt[0] = 1'b1;
              end else begin
                head_nxt = rec_q.nxt;
              end
              if (rec_q.nxt != NONE) begin
                nb_nxt[1] = '{addr: rec_q.nxt, set_next: 1'b0, val: rec_q.prv};
                nbv_nxt[1] = 1'b1;
              end
            end
          end else if (rec_q.cls == CLS_FULL) begin
            rec_wdata.cls = CLS_PARTIAL;
            rec_wdata.prv = NONE;
            rec_wdata.nxt = head_r;
            head_nxt      = PW'(s_r);
            if (head_r != NONE) begin
              nb_nxt[0] = '{addr: head_r, set_next: 1'b0, val: PW'(s_r)};
              nbv_nxt[0] = 1'b1;
            end
          end
        end
      end

      // Popped object read back from the stack RAM.
      S_STK: begin
        res_go_nxt = stk_q;
      end

      // Read the neighbor record named by the pending link update.
      S_NBRD: begin
        rec_raddr = SW'(nb_cur.addr);
      end

      // Rewrite one link field of the neighbor record.
      S_NBWR: begin
        if (nb_cur.set_next) begin
          nb_rec.nxt = nb_cur.val;
        end else begin
          nb_rec.prv = nb_cur.val;
        end
        rec_we           = 1'b1;
        rec_waddr        = SW'(nb_cur.addr);
        rec_wdata        = nb_rec;
        nbv_nxt[nb_sel]  = 1'b0;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_RESET;
      unused_r    <= '0;
      head_r      <= NONE;
      nbv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      unused_r    <= unused_nxt;
      head_r      <= head_nxt;
      nbv_r       <= nbv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    bad_r    <= bad_nxt;
    s_r      <= s_nxt;
    oi_r     <= oi_nxt;
    nb_r     <= nb_nxt;
    res_st_r <= res_st_nxt;
    res_gs_r <= res_gs_nxt;
    res_go_r <= res_go_nxt;
    if (state_r == S_DONE && out_free) begin
      out_st_r <= res_st_r;
      out_gs_r <= SLAB_W'(res_gs_r);
      out_go_r <= OBJ_W'(res_go_r);
    end
  end

  // A live list head is always a claimed slab.
  `SOA_ASSERT_IMP(a_head_claimed, head_r != NONE, head_r < unused_r, "list head not claimed")
  // The slab counter never runs past the pool.
  `SOA_ASSERT_IMP(a_unused_range, 1'b1, unused_r <= NONE, "slab counter out of range")
  // One beat at a time: no new beat right after an accept.
  `SOA_ASSERT_NXT(a_one_beat, in_acc, !in_tready, "beat accepted while busy")
  // A neighbor rewrite always has a pending link update.
  `SOA_ASSERT_IMP(a_nb_pending, state_r == S_NBWR, nbv_r != '0, "neighbor write without update")

endmodule

/* dv/slab_object_allocator_core_tb.sv */
// Testbench of the slab object allocator core: directed and random command streams.
// Depends on soa_pkg and slab_object_allocator_core; results are checked against
// a behavioral model of the slab pool kept inside this file.
module slab_object_allocator_core_tb;
  import soa_pkg::*;

  localparam int NSLAB = 16;
  localparam int NOBJ  = 128;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [1:0] K_UNUSED = 2'd0;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata;   // slab_index[3:0], object_index[10:4]
  logic [CMD_W-1:0] in_tuser;    // command[1:0]
  logic out_tvalid;
  logic out_tready;
  logic [DATA_W-1:0] out_tdata;  // granted_slab[3:0], granted_object[10:4]
  logic [STAT_W-1:0] out_tuser;  // status[1:0]

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLAB_W-1:0] slab;
    logic [OBJ_W-1:0] obj;
  } grant_t;

  // Model of the pool.
  logic [1:0] pool_kind [NSLAB];
  int pool_used [NSLAB];
  int pool_total [NSLAB];
  int pool_stack [NSLAB][NOBJ];
  int link_next [NSLAB];
  int link_prev [NSLAB];
  int list_head;
  int per_slab;

  grant_t pending_grants[$];
  int errors;
  bit sink_stall_on;

  slab_object_allocator_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("tb: failure");
    $finish;
  end

  function automatic void pool_clear();
    for (int s = 0; s < NSLAB; s++) begin
      pool_kind[s] = K_UNUSED;
      pool_used[s] = 0;
      pool_total[s] = 0;
    end
    list_head = NSLAB;
  endfunction

  function automatic void list_push(int s);
    link_prev[s] = NSLAB;
    link_next[s] = list_head;
    if (list_head < NSLAB) link_prev[list_head] = s;
    list_head = s;
  endfunction

  function automatic void list_drop(int s);
    int p;
    int n;
    p = link_prev[s];
    n = link_next[s];
    if (p < NSLAB) link_next[p] = n;
    else list_head = n;
    if (n < NSLAB) link_prev[n] = p;
  endfunction

  // Works out the result of one command and advances the pool model.
  function automatic grant_t pool_apply(logic [1:0] cmd, int si, int oi);
    grant_t g;
    int s;
    int tot;
    g = '{status: ST_BAD_HANDLE, slab: '0, obj: '0};
    if (cmd == CMD_ALLOC) begin
      if (list_head >= NSLAB) begin
        for (s = 0; s < NSLAB; s++)
          if (pool_kind[s] == K_UNUSED) break;
        if (s < NSLAB) begin
          tot = per_slab < 1 ? 1 : (per_slab > NOBJ ? NOBJ : per_slab);
          pool_total[s] = tot;
          pool_used[s] = 0;
          for (int k = 0; k < tot; k++) pool_stack[s][k] = k;
          pool_kind[s] = CLS_PARTIAL;
          list_push(s);
        end
      end
      if (list_head >= NSLAB) begin
        g.status = ST_NO_SLAB;
      end else begin
        s = list_head;
        g.obj = OBJ_W'(pool_stack[s][pool_total[s] - pool_used[s] - 1]);
        g.slab = SLAB_W'(s);
        pool_used[s]++;
        if (pool_used[s] >= pool_total[s]) begin
          list_drop(s);
          pool_kind[s] = CLS_FULL;
        end
        g.status = ST_OK;
      end
    end else if (cmd == CMD_FREE) begin
      if ((pool_kind[si] == CLS_PARTIAL || pool_kind[si] == CLS_FULL) &&
          oi < pool_total[si]) begin
        pool_stack[si][pool_total[si] - pool_used[si]] = oi;
        if (pool_kind[si] == CLS_FULL) begin
          pool_kind[si] = CLS_PARTIAL;
          list_push(si);
        end
        pool_used[si]--;
        if (pool_used[si] == 0) begin
          list_drop(si);
          pool_kind[si] = CLS_EMPTY;
        end
        g.status = ST_OK;
      end
    end else if (cmd == CMD_DESTROY) begin
      pool_clear();
      g.status = ST_DESTROYED;
    end
    return g;
  endfunction

  // Result checker: compares each accepted beat with the oldest expectation.
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result status=%0d data=%h", $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = pending_grants.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          errors++;
        end
        if (out_tdata[3:0] !== want.slab) begin
          $display("%0t: slab expected %0d actual %0d", $time, want.slab, out_tdata[3:0]);
          errors++;
        end
        if (out_tdata[10:4] !== want.obj) begin
          $display("%0t: object expected %0d actual %0d", $time, want.obj, out_tdata[10:4]);
          errors++;
        end
        if (out_tdata[15:11] !== 5'd0) begin
          $display("%0t: pad expected 0 actual %0d", $time, out_tdata[15:11]);
          errors++;
        end
      end
    end
  end

  // Result receiver: random stalls per beat, with stall-free stretches.
  initial begin
    int w;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      w = sink_stall_on ? $urandom_range(0, 14) : 0;
      out_tready = 1'b0;
      repeat (w) @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  bit gaps_on;

  // Sends one command beat and records its expected result.
  task automatic send_cmd(logic [1:0] cmd, int si, int oi);
    int w;
    int sm;
    int om;
    sm = si & 15;
    om = oi & 127;
    w = gaps_on ? $urandom_range(0, 14) : 0;
    repeat (w) @(negedge clk);
    in_tuser = cmd;
    in_tdata = {5'd0, om[6:0], sm[3:0]};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_grants.push_back(pool_apply(cmd, sm, om));
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tuser = CMD_W'($urandom);
    in_tdata = DATA_W'($urandom);
  endtask

  task automatic drain();
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(int v);
    drain();
    cfg_data = CFG_W'(v);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    per_slab = v & 255;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Directed: exhaustion, frees of empty and unclaimed slabs, unknown command.
  task automatic test_directed();
    write_cfg(0);
    for (int i = 0; i < 17; i++) send_cmd(CMD_ALLOC, 0, 0);
    send_cmd(CMD_FREE, 3, 0);
    send_cmd(CMD_FREE, 3, 0);
    send_cmd(CMD_FREE, 3, 127);
    send_cmd(CMD_UNKNOWN, 15, 127);
    send_cmd(CMD_DESTROY, 0, 0);
    write_cfg(255);
    send_cmd(CMD_ALLOC, 0, 0);
    send_cmd(CMD_FREE, 0, 127);
    send_cmd(CMD_FREE, 15, 5);
    send_cmd(CMD_ALLOC, 0, 0);
  endtask

  // Random: mostly allocs and frees of live handles, with noise and destroys.
  task automatic test_random(int count, int cfgv);
    int r;
    int s;
    write_cfg(cfgv);
    send_cmd(CMD_DESTROY, 0, 0);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, NSLAB - 1);
      if (r < 45) send_cmd(CMD_ALLOC, $urandom, $urandom);
      else if (r < 85 && pool_used[s] > 0)
        send_cmd(CMD_FREE, s, $urandom_range(0, pool_total[s] - 1));
      else if (r < 97) send_cmd(CMD_FREE, $urandom, $urandom);
      else if (r < 99) send_cmd(CMD_UNKNOWN, $urandom, $urandom);
      else send_cmd(CMD_DESTROY, $urandom, $urandom);
    end
  endtask

  initial begin
    errors = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    per_slab = CFG_RESET;
    gaps_on = 1'b0;
    sink_stall_on = 1'b0;
    pool_clear();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    gaps_on = 1'b1;
    sink_stall_on = 1'b1;
    test_random(200, 1);
    test_random(200, 5);
    gaps_on = 1'b0;
    test_random(150, 128);
    sink_stall_on = 1'b0;
    test_random(150, 3);
    gaps_on = 1'b1;
    sink_stall_on = 1'b1;
    test_random(150, 200);
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
